/* hdl/qte_pkg.sv */
`default_nettype none
package qte_pkg;

    // product sums: sine and cosine terms, Q28 signed
    localparam int TW = 34;
    // CORDIC x / y datapath width, leaves room for vector gain
    localparam int CW = 37;
    // Q30 angle accumulator
    localparam int ZW = 33;
    // radicand and square root widths
    localparam int RW = 57;
    localparam int SW = 29;
    localparam int SQRT_STAGES = 29;
    localparam int ATAN_LEN = 24;
    localparam int FRONT_STAGES = 5;

    localparam logic signed [TW-1:0] ONE_Q28 = TW'(1) <<< 28;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(1686629713);
    localparam logic signed [15:0] LIMIT_PI = 16'sd25736;
    localparam logic signed [14:0] LIMIT_HALF_PI = 15'sd12868;

    // word after the product stages
    typedef struct packed {
        logic signed [TW-1:0] sr;
        logic signed [TW-1:0] cr;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sp;
        logic                 clamp;
        logic signed [19:0]   tx;
        logic signed [19:0]   ty;
        logic signed [19:0]   tz;
    } t_front;

    // what rides alongside the CORDIC lanes
    typedef struct packed {
        logic               clamp;
        logic               sp_neg;
        logic signed [19:0] tx;
        logic signed [19:0] ty;
        logic signed [19:0] tz;
    } t_tail;

    // atan(2^-i) in Q30, truncated
    function automatic logic [30:0] atan_q30(input int idx);
        logic [30:0] v;
        case (idx)
            0:  v = 31'd843314856;
            1:  v = 31'd497837829;
            2:  v = 31'd263043836;
            3:  v = 31'd133525158;
            4:  v = 31'd67021686;
            5:  v = 31'd33543515;
            6:  v = 31'd16775850;
            7:  v = 31'd8388437;
            8:  v = 31'd4194282;
            9:  v = 31'd2097149;
            10: v = 31'd1048575;
            11: v = 31'd524287;
            12: v = 31'd262143;
            13: v = 31'd131071;
            14: v = 31'd65535;
            15: v = 31'd32767;
            16: v = 31'd16383;
            17: v = 31'd8191;
            18: v = 31'd4095;
            19: v = 31'd2047;
            20: v = 31'd1023;
            21: v = 31'd511;
            22: v = 31'd255;
            23: v = 31'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hdl/qte_front.sv */
`default_nettype none
module qte_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic signed [15:0]          i_w,
    input  wire logic signed [15:0]          i_x,
    input  wire logic signed [15:0]          i_y,
    input  wire logic signed [15:0]          i_z,
    input  wire logic signed [19:0]          i_tx,
    input  wire logic signed [19:0]          i_ty,
    input  wire logic signed [19:0]          i_tz,
    output logic                             o_valid,
    output qte_pkg::t_front                  o_word,
    output logic [qte_pkg::RW-1:0]           o_rad
);
    import qte_pkg::*;

    logic [FRONT_STAGES-1:0] r_v;

    // stage 1: products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic signed [19:0] r_tx1, r_ty1, r_tz1;

    // stage 2..5 words
    t_front r_f2, r_f3, r_f4, r_f5;
    logic [27:0] r_spm;
    logic [55:0] r_sq;
    logic [RW-1:0] r_rad;

    logic signed [32:0] n_sum_r, n_sum_cr, n_sum_y, n_sum_cy, n_sum_p;
    t_front n_f2, n_f3;

    always_comb begin
        n_sum_r  = 33'(r_wx) + 33'(r_yz);
        n_sum_cr = 33'(r_xx) + 33'(r_yy);
        n_sum_y  = 33'(r_wz) + 33'(r_xy);
        n_sum_cy = 33'(r_yy) + 33'(r_zz);
        n_sum_p  = 33'(r_wy) - 33'(r_zx);
        n_f2.sr = {n_sum_r, 1'b0};
        n_f2.cr = ONE_Q28 - {n_sum_cr, 1'b0};
        n_f2.sy = {n_sum_y, 1'b0};
        n_f2.cy = ONE_Q28 - {n_sum_cy, 1'b0};
        n_f2.sp = {n_sum_p, 1'b0};
        n_f2.clamp = 1'b0;
        n_f2.tx = r_tx1;
        n_f2.ty = r_ty1;
        n_f2.tz = r_tz1;
        // clamp decision on the pitch sine
        n_f3 = r_f2;
        n_f3.clamp = (r_f2.sp >= ONE_Q28) || (r_f2.sp <= -ONE_Q28);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
        r_wx <= i_w * i_x;
        r_yz <= i_y * i_z;
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_wz <= i_w * i_z;
        r_xy <= i_x * i_y;
        r_zz <= i_z * i_z;
        r_wy <= i_w * i_y;
        r_zx <= i_z * i_x;
        r_tx1 <= i_tx;
        r_ty1 <= i_ty;
        r_tz1 <= i_tz;
        r_f2 <= n_f2;
        r_f3 <= n_f3;
        r_spm <= r_f2.sp[TW-1] ? 28'(-r_f2.sp) : r_f2.sp[27:0];
        r_f4 <= r_f3;
        r_sq <= 56'(r_spm) * 56'(r_spm);
        r_f5 <= r_f4;
        r_rad <= (RW'(1) << 56) - RW'(r_sq);
    end

    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_word  = r_f5;
    assign o_rad   = r_rad;

endmodule
`default_nettype wire

/* hdl/qte_isqrt.sv */
`default_nettype none
module qte_isqrt (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [qte_pkg::RW-1:0]  i_rad,
    output logic                         o_valid,
    output logic [qte_pkg::SW-1:0]       o_root
);
    import qte_pkg::*;

    localparam int AW = 58;

    logic          r_v    [0:SQRT_STAGES];
    logic [AW-1:0] r_root [0:SQRT_STAGES];
    logic [AW-1:0] r_rem  [0:SQRT_STAGES];

    always_comb begin
        r_v[0]    = i_valid;
        r_root[0] = '0;
        r_rem[0]  = AW'(i_rad);
    end

    // one result bit per stage, trial bit 4^(28-k)
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        localparam logic [AW-1:0] BIT = AW'(1) << (56 - 2 * k);
        logic [AW:0] trial;
        assign trial = {1'b0, r_root[k]} + {1'b0, BIT};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            if ({1'b0, r_rem[k]} >= trial) begin
                r_rem[k+1]  <= r_rem[k] - trial[AW-1:0];
                r_root[k+1] <= (r_root[k] >> 1) + BIT;
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k] >> 1;
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES];
    assign o_root  = r_root[SQRT_STAGES][SW-1:0];

endmodule
`default_nettype wire

/* hdl/qte_cordic.sv */
`default_nettype none
module qte_cordic #(
    parameter int STEPS = 16,
    parameter int LIMIT = 25736
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic signed [qte_pkg::CW-1:0]  i_y,
    input  wire logic signed [qte_pkg::CW-1:0]  i_x,
    output logic                                o_valid,
    output logic signed [15:0]                  o_angle
);
    import qte_pkg::*;

    localparam int N = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
    localparam logic signed [16:0] LIM = 17'(LIMIT);

    logic                 r_v    [0:N];
    logic                 r_zero [0:N];
    logic signed [CW-1:0] r_x    [0:N];
    logic signed [CW-1:0] r_y    [0:N];
    logic signed [ZW-1:0] r_z    [0:N];
    logic                 r_vo;
    logic signed [15:0]   r_angle;

    // quadrant fold for a negative x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0 && i_y >= 0) begin
            r_x[0] <= i_y;
            r_y[0] <= -i_x;
            r_z[0] <= HALF_PI_Q30;
        end else if (i_x < 0) begin
            r_x[0] <= -i_y;
            r_y[0] <= i_x;
            r_z[0] <= -HALF_PI_Q30;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(i));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ANG;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ANG;
            end
        end
    end

    // round half up to Q2.13 and saturate
    logic signed [ZW:0] rnd;
    logic signed [16:0] q;
    assign rnd = {r_z[N][ZW-1], r_z[N]} + (ZW+1)'(65536);
    assign q   = rnd[ZW:17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[N];
        end
        if (r_zero[N]) begin
            r_angle <= '0;
        end else if (q > LIM) begin
            r_angle <= LIM[15:0];
        end else if (q < -LIM) begin
            r_angle <= 16'(-LIM);
        end else begin
            r_angle <= q[15:0];
        end
    end

    assign o_valid = r_vo;
    assign o_angle = r_angle;

endmodule
`default_nettype wire

/* hdl/quaternion_to_euler_angles_top.sv */
// Quaternion to roll / pitch / yaw. A pose is taken whenever start is high;
// busy is always low, so one pose can enter every clock cycle. Each pose gives
// one result word, marked by o_valid for a single cycle, after it passes
// through the product and square logic, the bit-per-stage square root for the
// pitch cosine, the quadrant fold, the CORDIC iterations and the rounding
// register. The receiver cannot stall and must take every word.
`default_nettype none
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [19:0] i_trans_x,
    input  wire logic signed [19:0] i_trans_y,
    input  wire logic signed [19:0] i_trans_z,
    output logic                    o_valid,
    output logic signed [19:0]      o_pos_x,
    output logic signed [19:0]      o_pos_y,
    output logic signed [19:0]      o_pos_z,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic signed [15:0]      o_yaw_angle,
    output logic                    o_pitch_clamped
);
    import qte_pkg::*;

    localparam int N = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int TAIL = N + 2;

    assign busy = 1'b0;

    logic          f_valid;
    t_front        f_word;
    logic [RW-1:0] f_rad;

    qte_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (start),
        .i_w (i_quat_w), .i_x (i_quat_x), .i_y (i_quat_y), .i_z (i_quat_z),
        .i_tx (i_trans_x), .i_ty (i_trans_y), .i_tz (i_trans_z),
        .o_valid (f_valid), .o_word (f_word), .o_rad (f_rad)
    );

    logic          s_valid;
    logic [SW-1:0] s_root;

    qte_isqrt u_isqrt (
        .i_clk, .i_rst_n,
        .i_valid (f_valid), .i_rad (f_rad),
        .o_valid (s_valid), .o_root (s_root)
    );

    // front word waits out the square root
    t_front r_fd [0:SQRT_STAGES-1];
    always_ff @(posedge i_clk) begin
        r_fd[0] <= f_word;
        for (int k = 1; k < SQRT_STAGES; k++) begin
            r_fd[k] <= r_fd[k-1];
        end
    end

    t_front d;
    assign d = r_fd[SQRT_STAGES-1];

    logic roll_v, pitch_v, yaw_v;
    logic signed [15:0] roll_a, pitch_a, yaw_a;

    qte_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(25736)) u_roll (
        .i_clk, .i_rst_n, .i_valid (s_valid),
        .i_y ({{(CW-TW){d.sr[TW-1]}}, d.sr}),
        .i_x ({{(CW-TW){d.cr[TW-1]}}, d.cr}),
        .o_valid (roll_v), .o_angle (roll_a)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(25736)) u_yaw (
        .i_clk, .i_rst_n, .i_valid (s_valid),
        .i_y ({{(CW-TW){d.sy[TW-1]}}, d.sy}),
        .i_x ({{(CW-TW){d.cy[TW-1]}}, d.cy}),
        .o_valid (yaw_v), .o_angle (yaw_a)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(12868)) u_pitch (
        .i_clk, .i_rst_n, .i_valid (s_valid),
        .i_y ({{(CW-TW){d.sp[TW-1]}}, d.sp}),
        .i_x ({{(CW-SW){1'b0}}, s_root}),
        .o_valid (pitch_v), .o_angle (pitch_a)
    );

    // pass-through fields follow the CORDIC lanes
    t_tail r_td [0:TAIL-1];
    t_tail n_tail;
    always_comb begin
        n_tail.clamp  = d.clamp;
        n_tail.sp_neg = d.sp[TW-1];
        n_tail.tx     = d.tx;
        n_tail.ty     = d.ty;
        n_tail.tz     = d.tz;
    end

    always_ff @(posedge i_clk) begin
        r_td[0] <= n_tail;
        for (int k = 1; k < TAIL; k++) begin
            r_td[k] <= r_td[k-1];
        end
    end

    t_tail t;
    assign t = r_td[TAIL-1];

    // result word; roll and yaw lanes run in lock-step with pitch
    assign o_valid         = pitch_v & roll_v & yaw_v;
    assign o_pos_x         = t.tx;
    assign o_pos_y         = t.ty;
    assign o_pos_z         = t.tz;
    assign o_roll_angle    = roll_a;
    assign o_yaw_angle     = yaw_a;
    assign o_pitch_clamped = t.clamp;
    assign o_pitch_angle   = !t.clamp ? pitch_a[14:0] :
                             (t.sp_neg ? -LIMIT_HALF_PI : LIMIT_HALF_PI);

endmodule
`default_nettype wire

/* hdl/qte_checker.sv */
`default_nettype none
module qte_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic signed [15:0] o_roll_angle,
    input wire logic signed [14:0] o_pitch_angle,
    input wire logic signed [15:0] o_yaw_angle,
    input wire logic               o_pitch_clamped
);
    import qte_pkg::*;

    localparam int N = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int LAT = FRONT_STAGES + SQRT_STAGES + N + 2;

    // every word traces back to a start a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result word without matching start");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pitch_clamped) |->
            (o_pitch_angle == 15'sd12868 || o_pitch_angle == -15'sd12868))
        else $error("clamped pitch not at half pi");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= 16'sd25736 && o_roll_angle >= -16'sd25736
                     && o_yaw_angle <= 16'sd25736 && o_yaw_angle >= -16'sd25736))
        else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles_top qte_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_qte_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid,
    .o_roll_angle, .o_pitch_angle, .o_yaw_angle, .o_pitch_clamped
);
`default_nettype wire
